// ----- hw/rtl/keyed_size_registry_table_unit_macros.svh -----
// Assertion macros for the keyed size registry table.
// Taken in by the top level; needs no package.
`ifndef KEYED_SIZE_REGISTRY_TABLE_UNIT_MACROS_SVH
`define KEYED_SIZE_REGISTRY_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSZR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyed size registry check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KSZR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyed size registry check failed");

`endif

// ----- hw/rtl/kszr_pkg.sv -----
// Shared types, codes and default sizes of the keyed size registry table.
// No dependencies; every other file but the assertion macros imports it.
package kszr_pkg;

	localparam int MAX_ENTRIES_DEF   = 64;
	localparam int DEFAULT_SLOTS_DEF = 32;
	localparam int KEY_BITS_DEF      = 32;

	localparam int TASK_KEY_W   = 32;
	localparam int SIZE_VALUE_W = 32;
	localparam int SLOT_REQ_W   = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	typedef enum logic [1:0] {
		ACT_REGISTER = 2'd0,
		ACT_LOOKUP   = 2'd1,
		ACT_CLEAR    = 2'd2
	} kszr_action_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_INVALID  = 3'd3,
		ST_DISABLED = 3'd4,
		ST_FOUND    = 3'd5,
		ST_MISSING  = 3'd6,
		ST_CLEARED  = 3'd7
	} kszr_status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_REQUEST    = 1'd1;

	// Control strobes from the sequencer to the entry store.
	typedef struct packed {
		logic rd;
		logic wr;
		logic set_valid;
		logic clear_all;
	} kszr_mem_ctl_t;

endpackage

// ----- hw/rtl/kszr_if.sv -----
// Valid/ready channel interfaces of the keyed size registry table.
// Depends on kszr_pkg for the payload widths.
interface kszr_cmd_if;
	import kszr_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic [TASK_KEY_W-1:0]   task_key;
	logic [SIZE_VALUE_W-1:0] size_value;
	modport source (output valid, action, task_key, size_value, input ready);
	modport sink (input valid, action, task_key, size_value, output ready);
endinterface

interface kszr_rsp_if;
	import kszr_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [2:0]              status;
	logic [SIZE_VALUE_W-1:0] found_value;
	modport source (output valid, status, found_value, input ready);
	modport sink (input valid, status, found_value, output ready);
endinterface

interface kszr_cfg_if;
	import kszr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/keyed_size_registry_table_unit.sv -----
// Top level of the keyed size registry table: configuration registers,
// response register, sequencer and entry store. Depends on kszr_pkg,
// the channel interfaces, kszr_seq, kszr_store and the assertion macros.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------
//   cmd     | in  | action, task_key, size_value
//   rsp     | out | status, found_value
//   cfg     | in  | index (0 monitor_enabled, 1 slot_request), data
//
// A register or lookup beat walks the slots in use: the sequencer
// walks them one entry a cycle through the single synchronous read port
// of the key/value memory and one key comparator, and stops early on a
// hit. Clear, a rejected register and an unused action code go from idle
// straight to the done state. Reset clears the valid bits, the slots in
// use and the configuration at once; no clearing pass follows. A stalled
// response holds in its register while the sequencer may already take the
// next command beat.
module keyed_size_registry_table_unit #(
	parameter int MAX_ENTRIES   = kszr_pkg::MAX_ENTRIES_DEF,
	parameter int DEFAULT_SLOTS = kszr_pkg::DEFAULT_SLOTS_DEF,
	parameter int KEY_BITS      = kszr_pkg::KEY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kszr_cmd_if.sink   cmd,
	kszr_rsp_if.source rsp,
	kszr_cfg_if.sink   cfg
);
	import kszr_pkg::*;
	`include "keyed_size_registry_table_unit_macros.svh"

	localparam int AddrW = $clog2(MAX_ENTRIES);

	// Configuration registers. The user must write them only while the block
	// is idle; the block does not enforce this. The port is always ready.
	logic                  monitor_enabled_q;
	logic [SLOT_REQ_W-1:0] slot_request_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_enabled_q <= 1'b0;
			slot_request_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MONITOR_ENABLED: monitor_enabled_q <= cfg.data[0];
				CFG_SLOT_REQUEST:    slot_request_q    <= cfg.data[SLOT_REQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and store wiring.
	logic                    seq_idle;
	logic                    start;
	logic                    res_valid;
	logic                    res_ready;
	kszr_status_t            res_status;
	logic [SIZE_VALUE_W-1:0] res_value;
	kszr_mem_ctl_t           mem_ctl;
	logic [AddrW-1:0]        rd_addr;
	logic [AddrW-1:0]        wr_addr;
	logic [KEY_BITS-1:0]     wr_key;
	logic [SIZE_VALUE_W-1:0] wr_value;
	logic [KEY_BITS-1:0]     rd_key;
	logic [SIZE_VALUE_W-1:0] rd_value;
	logic                    rd_valid;

	assign cmd.ready = seq_idle;
	assign start     = cmd.valid && seq_idle;

	kszr_seq #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.DEFAULT_SLOTS (DEFAULT_SLOTS),
		.KEY_BITS      (KEY_BITS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.action          (cmd.action),
		.task_key        (cmd.task_key),
		.size_value      (cmd.size_value),
		.monitor_enabled (monitor_enabled_q),
		.slot_request    (slot_request_q),
		.idle            (seq_idle),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res_status      (res_status),
		.res_value       (res_value),
		.ctl             (mem_ctl),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.wr_key          (wr_key),
		.wr_value        (wr_value),
		.rd_key          (rd_key),
		.rd_value        (rd_value),
		.rd_valid        (rd_valid)
	);

	kszr_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_key   (wr_key),
		.wr_value (wr_value),
		.rd_key   (rd_key),
		.rd_value (rd_value),
		.rd_valid (rd_valid)
	);

	// Response register: it decouples the sequencer from a stalled sink.
	logic                    rsp_valid_q;
	kszr_status_t            rsp_status_q;
	logic [SIZE_VALUE_W-1:0] rsp_value_q;

	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_status_q <= res_status;
			rsp_value_q  <= res_value;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_value = rsp_value_q;

	// The sequencer is busy in the cycle after it takes a command.
	`KSZR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)
	// A finished result waits in the sequencer until the response register frees.
	`KSZR_ASSERT_NEXT(a_result_held, clk, arst_n, res_valid && !res_ready, res_valid)
	// Only a lookup hit carries a value.
	`KSZR_ASSERT_IMPL(a_value_only_on_hit, clk, arst_n, rsp.valid && (rsp.status != ST_FOUND), rsp.found_value == '0)
	// Stored values are never zero, so a hit always carries a nonzero value.
	`KSZR_ASSERT_IMPL(a_hit_nonzero, clk, arst_n, rsp.valid && (rsp.status == ST_FOUND), rsp.found_value != '0)

endmodule

// ----- hw/rtl/kszr_store.sv -----
// Entry store: key and value memories with one registered read port,
// plus the per-entry valid bits. Depends on kszr_pkg.
module kszr_store #(
	parameter int MAX_ENTRIES = kszr_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = kszr_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kszr_pkg::kszr_mem_ctl_t         ctl,
	input  logic [$clog2(MAX_ENTRIES)-1:0]  rd_addr,
	input  logic [$clog2(MAX_ENTRIES)-1:0]  wr_addr,
	input  logic [KEY_BITS-1:0]             wr_key,
	input  logic [kszr_pkg::SIZE_VALUE_W-1:0] wr_value,
	output logic [KEY_BITS-1:0]             rd_key,
	output logic [kszr_pkg::SIZE_VALUE_W-1:0] rd_value,
	output logic                            rd_valid
);
	import kszr_pkg::*;

	logic [KEY_BITS-1:0]     key_mem [MAX_ENTRIES];
	logic [SIZE_VALUE_W-1:0] val_mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_value;
		end
		if (ctl.rd) begin
			rd_key   <= key_mem[rd_addr];
			rd_value <= val_mem[rd_addr];
			rd_valid <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear_all) begin
			valid_q <= '0;
		end else if (ctl.set_valid) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

endmodule

// ----- hw/rtl/kszr_seq.sv -----
// Sequencer: decodes a command, then walks the slots in use one entry a
// cycle through the single compare unit. Depends on kszr_pkg.
module kszr_seq #(
	parameter int MAX_ENTRIES   = kszr_pkg::MAX_ENTRIES_DEF,
	parameter int DEFAULT_SLOTS = kszr_pkg::DEFAULT_SLOTS_DEF,
	parameter int KEY_BITS      = kszr_pkg::KEY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [1:0]                        action,
	input  logic [kszr_pkg::TASK_KEY_W-1:0]   task_key,
	input  logic [kszr_pkg::SIZE_VALUE_W-1:0] size_value,
	input  logic                              monitor_enabled,
	input  logic [kszr_pkg::SLOT_REQ_W-1:0]   slot_request,
	output logic                              idle,
	output logic                              res_valid,
	input  logic                              res_ready,
	output kszr_pkg::kszr_status_t            res_status,
	output logic [kszr_pkg::SIZE_VALUE_W-1:0] res_value,
	output kszr_pkg::kszr_mem_ctl_t           ctl,
	output logic [$clog2(MAX_ENTRIES)-1:0]    rd_addr,
	output logic [$clog2(MAX_ENTRIES)-1:0]    wr_addr,
	output logic [KEY_BITS-1:0]               wr_key,
	output logic [kszr_pkg::SIZE_VALUE_W-1:0] wr_value,
	input  logic [KEY_BITS-1:0]               rd_key,
	input  logic [kszr_pkg::SIZE_VALUE_W-1:0] rd_value,
	input  logic                              rd_valid
);
	import kszr_pkg::*;

	localparam int AddrW  = $clog2(MAX_ENTRIES);
	localparam int CntW   = $clog2(MAX_ENTRIES + 1);
	localparam int CmpW   = (CntW > SLOT_REQ_W) ? CntW : SLOT_REQ_W;
	localparam int DefSat = (DEFAULT_SLOTS > MAX_ENTRIES) ? MAX_ENTRIES : DEFAULT_SLOTS;
	localparam logic [CmpW-1:0] MaxC = CmpW'(MAX_ENTRIES);
	localparam logic [CmpW-1:0] DefC = CmpW'(DefSat);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              is_reg_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [SIZE_VALUE_W-1:0] val_q;
	logic [CntW-1:0]   slots_q;
	logic [CntW-1:0]   limit_q;
	logic [CntW-1:0]   issue_idx_q;
	logic              chk_s1;
	logic [AddrW-1:0]  chk_idx_s1;
	logic              free_found_q;
	logic [AddrW-1:0]  free_idx_q;
	kszr_status_t      status_q;
	logic [SIZE_VALUE_W-1:0] value_q;

	logic [63:0]       key_wide;
	logic [KEY_BITS-1:0] key_in;
	logic [CmpW-1:0]   req_c;
	logic [CmpW-1:0]   target_c;
	logic [CntW-1:0]   target;
	logic [CntW-1:0]   new_slots;
	logic              more;
	logic              key_hit;
	logic              issue;
	logic              scan_end;

	always_comb begin
		key_wide  = {32'd0, task_key};
		key_in    = key_wide[KEY_BITS-1:0];
		req_c     = CmpW'(slot_request);
		if (req_c == '0) begin
			target_c = DefC;
		end else if (req_c > MaxC) begin
			target_c = MaxC;
		end else begin
			target_c = req_c;
		end
		target    = target_c[CntW-1:0];
		new_slots = (target > slots_q) ? target : slots_q;

		more     = issue_idx_q < limit_q;
		key_hit  = (state_q == S_SCAN) && chk_s1 && rd_valid && (rd_key == key_q);
		issue    = (state_q == S_SCAN) && !key_hit && more;
		scan_end = (state_q == S_SCAN) && !chk_s1 && !more;

		ctl.rd        = issue;
		ctl.wr        = 1'b0;
		ctl.set_valid = 1'b0;
		ctl.clear_all = start && (action == ACT_CLEAR);
		rd_addr       = issue_idx_q[AddrW-1:0];
		wr_addr       = chk_idx_s1;
		wr_key        = key_q;
		wr_value      = val_q;
		if (key_hit && is_reg_q) begin
			ctl.wr = 1'b1;
		end else if (scan_end && is_reg_q && free_found_q) begin
			ctl.wr        = 1'b1;
			ctl.set_valid = 1'b1;
			wr_addr       = free_idx_q;
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res_status = status_q;
	assign res_value  = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slots_q      <= '0;
			chk_s1       <= 1'b0;
			chk_idx_s1   <= '0;
			issue_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			is_reg_q     <= 1'b0;
			key_q        <= '0;
			val_q        <= '0;
			limit_q      <= '0;
			status_q     <= ST_INVALID;
			value_q      <= '0;
		end else begin
			chk_s1     <= issue;
			chk_idx_s1 <= issue_idx_q[AddrW-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						issue_idx_q  <= '0;
						free_found_q <= 1'b0;
						key_q        <= key_in;
						val_q        <= size_value;
						value_q      <= '0;
						unique case (action)
							ACT_REGISTER: begin
								if (!monitor_enabled) begin
									status_q <= ST_DISABLED;
									state_q  <= S_DONE;
								end else if (key_in == '0 || size_value == '0) begin
									status_q <= ST_INVALID;
									state_q  <= S_DONE;
								end else begin
									slots_q  <= new_slots;
									limit_q  <= new_slots;
									is_reg_q <= 1'b1;
									state_q  <= S_SCAN;
								end
							end
							ACT_LOOKUP: begin
								if (slots_q == '0) begin
									status_q <= ST_MISSING;
									state_q  <= S_DONE;
								end else begin
									limit_q  <= slots_q;
									is_reg_q <= 1'b0;
									state_q  <= S_SCAN;
								end
							end
							ACT_CLEAR: begin
								slots_q  <= '0;
								status_q <= ST_CLEARED;
								state_q  <= S_DONE;
							end
							default: begin
								status_q <= ST_INVALID;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_idx_q <= issue_idx_q + CntW'(1);
					end
					if (chk_s1 && !rd_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= chk_idx_s1;
					end
					if (key_hit) begin
						status_q <= is_reg_q ? ST_UPDATED : ST_FOUND;
						value_q  <= is_reg_q ? '0 : rd_value;
						state_q  <= S_DONE;
					end else if (scan_end) begin
						if (!is_reg_q) begin
							status_q <= ST_MISSING;
						end else if (free_found_q) begin
							status_q <= ST_INSERTED;
						end else begin
							status_q <= ST_FULL;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for keyed_size_registry_table_unit: a directed
// opening followed by randomized phases. Needs kszr_pkg, the channel
// interfaces and the block itself; everything else is defined here.
module testbench;
	import kszr_pkg::*;

	localparam int CLK_PERIOD = 10;

	// Action code 3 is outside the enum; the block must answer it as invalid.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// A register or lookup walks at most every slot before its reply, so
	// this drain covers any beat still in flight.
	localparam int DRAIN_CYCLES = MAX_ENTRIES_DEF + 16;

	typedef struct {
		kszr_status_t            status;
		logic [SIZE_VALUE_W-1:0] found_value;
	} reply_t;

	// Scoreboard: keeps its own copy of the table and the two registers,
	// computes the reply that each accepted command beat must produce, and
	// checks reply beats against those replies in order.
	class size_table_checker;
		localparam int DEPTH        = MAX_ENTRIES_DEF;
		localparam int DEFAULT_SIZE = DEFAULT_SLOTS_DEF;

		bit [TASK_KEY_W-1:0]   slot_key[DEPTH];
		bit [SIZE_VALUE_W-1:0] slot_size[DEPTH];
		bit                    slot_live[DEPTH];
		int unsigned           slots_in_use;
		bit                    enabled;
		bit [SLOT_REQ_W-1:0]   slot_request;
		reply_t                replies_due[$];
		int unsigned           errors;

		function new();
			foreach (slot_live[i]) slot_live[i] = 1'b0;
			slots_in_use = 0;
			enabled      = 1'b0;
			slot_request = '0;
			errors       = 0;
		endfunction

		task flag(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_MONITOR_ENABLED)
				enabled = data[0];
			else
				slot_request = data[SLOT_REQ_W-1:0];
		endfunction

		function int find_key(bit [TASK_KEY_W-1:0] key);
			for (int i = 0; i < int'(slots_in_use) && i < DEPTH; i++) begin
				if (slot_live[i] && slot_key[i] == key)
					return i;
			end
			return -1;
		endfunction

		// Updates the table copy and returns the reply the block owes.
		function reply_t apply_command(logic [1:0] action, bit [TASK_KEY_W-1:0] key,
				bit [SIZE_VALUE_W-1:0] size);
			reply_t      r;
			int unsigned target;
			int          hit;
			r.status      = ST_INVALID;
			r.found_value = '0;
			case (action)
				ACT_REGISTER: begin
					if (!enabled) begin
						r.status = ST_DISABLED;
					end else if (key == '0 || size == '0) begin
						r.status = ST_INVALID;
					end else begin
						// The slots in use grow to the request, never shrink.
						target = (slot_request == '0) ? DEFAULT_SIZE : slot_request;
						if (target > DEPTH)
							target = DEPTH;
						if (slots_in_use < target)
							slots_in_use = target;
						hit = find_key(key);
						if (hit >= 0) begin
							slot_size[hit] = size;
							r.status = ST_UPDATED;
						end else begin
							r.status = ST_FULL;
							for (int i = 0; i < int'(slots_in_use) && i < DEPTH; i++) begin
								if (!slot_live[i]) begin
									slot_key[i]  = key;
									slot_size[i] = size;
									slot_live[i] = 1'b1;
									r.status     = ST_INSERTED;
									break;
								end
							end
						end
					end
				end
				ACT_LOOKUP: begin
					hit = find_key(key);
					if (hit >= 0 && key != '0) begin
						r.status      = ST_FOUND;
						r.found_value = slot_size[hit];
					end else begin
						r.status = ST_MISSING;
					end
				end
				ACT_CLEAR: begin
					foreach (slot_live[i]) slot_live[i] = 1'b0;
					slots_in_use = 0;
					r.status     = ST_CLEARED;
				end
				default: r.status = ST_INVALID;
			endcase
			return r;
		endfunction

		function void note_command(logic [1:0] action, logic [TASK_KEY_W-1:0] key,
				logic [SIZE_VALUE_W-1:0] size);
			replies_due.push_back(apply_command(action, key, size));
		endfunction

		task check_reply(logic [2:0] status, logic [SIZE_VALUE_W-1:0] found_value);
			reply_t want;
			if (replies_due.size() == 0) begin
				flag($sformatf("reply status %0d value %h with nothing outstanding",
					status, found_value));
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status)
					flag($sformatf("status %0d, expected %0d", status, want.status));
				if (found_value !== want.found_value)
					flag($sformatf("found_value %h, expected %h", found_value,
						want.found_value));
			end
		endtask

		function int outstanding();
			return replies_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	kszr_cmd_if cmd_ch();
	kszr_rsp_if rsp_ch();
	kszr_cfg_if cfg_ch();

	keyed_size_registry_table_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	size_table_checker table_check = new();

	// Percentages of cycles in which the command side holds off and the
	// reply side refuses a beat. The phases below change them.
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;

	bit [TASK_KEY_W-1:0] key_pool[];

	always #(CLK_PERIOD/2) clk = ~clk;

	// The reply side decides on every falling edge whether it takes a beat,
	// so stalls land on every phase of the block's work.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Every reply beat is checked at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			table_check.check_reply(rsp_ch.status, rsp_ch.found_value);
	end

	// Hard stop in case the block hangs; far beyond the slowest legal run.
	initial begin
		#(CLK_PERIOD * 4_000_000);
		$display("tb: failure");
		$finish;
	end

	// Drives one command beat, starting at a falling edge, with a random
	// hold-off first. Returns at the falling edge after the beat is taken,
	// leaving valid high so a following beat can go out back to back.
	task automatic issue(logic [1:0] action, logic [TASK_KEY_W-1:0] key,
			logic [SIZE_VALUE_W-1:0] size);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.action     <= action;
		cmd_ch.task_key   <= key;
		cmd_ch.size_value <= size;
		do @(posedge clk); while (!cmd_ch.ready);
		table_check.note_command(action, key, size);
		@(negedge clk);
	endtask

	// Drops the command valid and waits until every reply is in, so the
	// registers can be written with the block idle.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (table_check.outstanding() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		table_check.set_register(index, data);
		@(negedge clk);
	endtask

	// Writes both registers; the upper bits of the enable beat are noise
	// that the block must ignore.
	task automatic configure(bit enable, logic [SLOT_REQ_W-1:0] request);
		write_register(CFG_MONITOR_ENABLED, {(CFG_DATA_W-1)'($urandom), enable});
		write_register(CFG_SLOT_REQUEST, request);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic fill_key_pool(int unsigned count);
		key_pool = new[count];
		foreach (key_pool[i]) begin
			do key_pool[i] = $urandom; while (key_pool[i] == '0);
		end
	endtask

	// One random command beat. Keys mostly come from a small pool so that
	// updates, hits and a full table all occur; the rest is noise.
	task automatic random_command();
		int unsigned         pick;
		bit [TASK_KEY_W-1:0]   key;
		bit [SIZE_VALUE_W-1:0] size;
		pick = $urandom_range(99);
		key  = key_pool[$urandom_range(key_pool.size() - 1)];
		if ($urandom_range(9) == 0)
			key = $urandom;
		size = $urandom;
		if (pick < 48) begin
			issue(ACT_REGISTER, key, size);
		end else if (pick < 88) begin
			issue(ACT_LOOKUP, key, $urandom);
		end else if (pick < 93) begin
			if ($urandom_range(1))
				issue(ACT_REGISTER, '0, size);
			else
				issue(ACT_REGISTER, key, '0);
		end else if (pick < 96) begin
			issue(ACT_CLEAR, $urandom, $urandom);
		end else if (pick < 98) begin
			issue(ACT_UNUSED, $urandom, $urandom);
		end else begin
			issue(ACT_LOOKUP, '0, $urandom);
		end
	endtask

	initial begin
		int unsigned         items;
		bit                  enable;
		logic [SLOT_REQ_W-1:0] request;

		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.action     = ACT_LOOKUP;
		cmd_ch.task_key   = '0;
		cmd_ch.size_value = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_MONITOR_ENABLED;
		cfg_ch.data       = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Right after reset registration is off: even a zero key must be
		// refused as not enabled, since that check comes first. Lookups,
		// clear and the unused action code still answer.
		issue(ACT_REGISTER, 32'd1, 32'd1);
		issue(ACT_REGISTER, '0, '0);
		issue(ACT_LOOKUP, '0, '0);
		issue(ACT_UNUSED, '1, '1);
		issue(ACT_CLEAR, '0, '0);
		settle();

		// Two usable slots: zero key and zero value are invalid, two inserts
		// fill the table, the third key is dropped, and a re-register of a
		// stored key updates it in place.
		configure(1'b1, 7'd2);
		issue(ACT_REGISTER, '0, 32'd5);
		issue(ACT_REGISTER, 32'd5, '0);
		issue(ACT_REGISTER, '1, '1);
		issue(ACT_REGISTER, 32'd1, 32'd1);
		issue(ACT_REGISTER, 32'd2, 32'd7);
		issue(ACT_LOOKUP, '1, '0);
		issue(ACT_REGISTER, 32'd1, 32'h8000_0000);
		issue(ACT_LOOKUP, 32'd1, '1);
		issue(ACT_LOOKUP, 32'd2, '0);
		issue(ACT_LOOKUP, '0, '0);
		settle();

		// A larger request grows the slots in use by one; then the table is
		// full again. Clear must forget everything.
		configure(1'b1, 7'd3);
		issue(ACT_REGISTER, 32'd2, 32'd7);
		issue(ACT_REGISTER, 32'd3, 32'd3);
		issue(ACT_CLEAR, '1, '1);
		issue(ACT_LOOKUP, '1, '0);
		settle();

		// A request past the table size saturates at the table size.
		configure(1'b1, 7'd127);
		issue(ACT_REGISTER, 32'haaaa_aaaa, 32'h5555_5555);
		issue(ACT_REGISTER, 32'h5555_5555, 32'haaaa_aaaa);
		issue(ACT_LOOKUP, 32'haaaa_aaaa, '0);
		issue(ACT_LOOKUP, 32'h5555_5555, '0);
		issue(ACT_CLEAR, '0, '0);
		settle();

		// Random phases: each sets its own registers, handshake pressure and
		// key pool, and opens with a clear so the new request takes effect
		// on an empty table. One phase runs with registration off.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin enable = 1'b1; request = 7'd0; end
				1: begin enable = 1'b1; request = 7'd64; end
				2: begin enable = 1'b1; request = 7'd1; end
				3: begin enable = 1'b1; request = 7'd127; end
				4: begin enable = 1'b0; request = 7'd17; end
				5: begin enable = 1'b1; request = 7'($urandom_range(63, 2)); end
				6: begin enable = 1'b1; request = 7'd8; end
				default: begin enable = 1'b1; request = 7'd33; end
			endcase
			case (phase % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
				default: begin src_idle_pct = 22; snk_stall_pct = 22; end
			endcase
			case ($urandom_range(3))
				0: fill_key_pool(4);
				1: fill_key_pool(12);
				2: fill_key_pool(40);
				default: fill_key_pool(90);
			endcase
			items = enable ? 240 : 80;
			configure(enable, request);
			issue(ACT_CLEAR, $urandom, $urandom);
			repeat (items) random_command();
			settle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (table_check.outstanding() != 0)
			table_check.flag($sformatf("%0d replies never arrived",
				table_check.outstanding()));
		if (table_check.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
